// ----- sv/mtep_pkg.sv -----
`timescale 1ns / 1ps

package mtep_pkg;

  // Status bytes with special handling
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_ESCAPE   = 8'hF7;
  localparam logic [7:0] ST_SONG_POS = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL = 8'hF3;
  localparam logic [7:0] META_EOT    = 8'h2F;

  // Upper nibbles of channel messages
  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_POLY     = 4'hA;
  localparam logic [3:0] NIB_CTRL     = 4'hB;
  localparam logic [3:0] NIB_PROG     = 4'hC;
  localparam logic [3:0] NIB_PRESS    = 4'hD;
  localparam logic [3:0] NIB_PITCH    = 4'hE;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic       track_start;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] delta_time;
    logic [31:0] total_time;
    logic [7:0]  status;
    logic [7:0]  type_or_data1;
    logic [7:0]  data2;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
    logic        end_of_track;
  } res_t;

endpackage

// ----- sv/mtep_in_stage.sv -----
`timescale 1ns / 1ps

module mtep_in_stage
  import mtep_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_beat,
  input  logic     take,
  output logic     held_valid,
  output in_beat_t held_beat
);

  logic     valid_r;
  logic     valid_nxt;
  in_beat_t beat_r;

  // A held beat leaves in the same cycle a new one arrives.
  assign in_ready   = !valid_r || take;
  assign held_valid = valid_r;
  assign held_beat  = beat_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

endmodule

// ----- sv/mtep_parse.sv -----
`timescale 1ns / 1ps

module mtep_parse
  import mtep_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  in_beat_t beat,
  output logic     res_valid,
  output res_t     res
);

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_METATYPE,
    PH_LEN,
    PH_PAYLOAD,
    PH_DATA1,
    PH_DATA2,
    PH_SKIP
  } phase_t;

  localparam int TW = TIME_WIDTH;

  phase_t          phase_r, phase_nxt, c_phase;
  logic [7:0]      rs_r, rs_nxt, c_rs;
  logic [7:0]      cs_r, cs_nxt, c_cs;
  logic [TW-1:0]   dacc_r, dacc_nxt, c_dacc;
  logic [TW-1:0]   total_r, total_nxt, c_total;
  logic [7:0]      fd_r, fd_nxt, c_fd;
  logic [7:0]      sd_r, sd_nxt, c_sd;
  logic [31:0]     lacc_r, lacc_nxt, c_lacc;
  logic [31:0]     brem_r, brem_nxt, c_brem;
  logic            ended_r, ended_nxt, c_ended;

  logic [7:0]      b;
  logic [7:0]      ev;
  logic            used;
  logic [31:0]     brem_dec;
  logic [TW+31:0]  dacc_ext;
  logic [TW+31:0]  total_ext;
  logic            end_evt;

  assign b = beat.data_byte;

  // A track start clears everything before the byte is parsed.
  always_comb begin
    c_phase = beat.track_start ? PH_DELTA : phase_r;
    c_rs    = beat.track_start ? 8'd0 : rs_r;
    c_cs    = beat.track_start ? 8'd0 : cs_r;
    c_dacc  = beat.track_start ? '0 : dacc_r;
    c_total = beat.track_start ? '0 : total_r;
    c_fd    = beat.track_start ? 8'd0 : fd_r;
    c_sd    = beat.track_start ? 8'd0 : sd_r;
    c_lacc  = beat.track_start ? 32'd0 : lacc_r;
    c_brem  = beat.track_start ? 32'd0 : brem_r;
    c_ended = beat.track_start ? 1'b0 : ended_r;
  end

  assign dacc_ext  = {32'd0, c_dacc};
  assign total_ext = {32'd0, c_total};
  assign brem_dec  = (c_brem != 32'd0) ? c_brem - 32'd1 : c_brem;

  // A data byte in status position reuses the running status, if there is one.
  assign used = !(!b[7] && (c_rs != 8'd0));
  assign ev   = used ? b : c_rs;

  always_comb begin
    phase_nxt = c_phase;
    rs_nxt    = c_rs;
    cs_nxt    = c_cs;
    dacc_nxt  = c_dacc;
    total_nxt = c_total;
    fd_nxt    = c_fd;
    sd_nxt    = c_sd;
    lacc_nxt  = c_lacc;
    brem_nxt  = c_brem;
    ended_nxt = c_ended;
    end_evt   = 1'b0;

    res_valid          = 1'b0;
    res.kind           = KIND_HEADER;
    res.delta_time     = dacc_ext[31:0];
    res.total_time     = total_ext[31:0];
    res.status         = c_cs;
    res.type_or_data1  = c_fd;
    res.data2          = c_sd;
    res.payload_length = 32'd0;
    res.payload_byte   = 8'd0;
    res.last           = 1'b1;
    res.end_of_track   = 1'b0;

    if (!c_ended) begin
      case (c_phase)
        PH_DELTA: begin
          dacc_nxt = {c_dacc[TW-8:0], b[6:0]};
          if (!b[7]) begin
            total_nxt = c_total + dacc_nxt;
            fd_nxt    = 8'd0;
            sd_nxt    = 8'd0;
            lacc_nxt  = 32'd0;
            brem_nxt  = 32'd0;
            phase_nxt = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (!(ev inside {ST_META, ST_SYSEX, ST_ESCAPE})) begin
            rs_nxt = ev;
          end
          cs_nxt     = ev;
          res.status = ev;
          if (ev == ST_META) begin
            phase_nxt = PH_METATYPE;
          end else if (ev inside {ST_SYSEX, ST_ESCAPE}) begin
            lacc_nxt  = 32'd0;
            phase_nxt = PH_LEN;
          end else if (ev inside {ST_SONG_POS, ST_SONG_SEL}) begin
            if (used) begin
              brem_nxt  = (ev == ST_SONG_POS) ? 32'd2 : 32'd1;
              phase_nxt = PH_SKIP;
            end else if (ev == ST_SONG_SEL) begin
              // The byte itself is the one skipped byte.
              brem_nxt  = 32'd0;
              res_valid = 1'b1;
              end_evt   = 1'b1;
            end else begin
              brem_nxt  = 32'd1;
              phase_nxt = PH_SKIP;
            end
          end else if (ev[7:4] inside {NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY, NIB_CTRL,
                                       NIB_PITCH, NIB_PROG, NIB_PRESS}) begin
            if (used) begin
              phase_nxt = PH_DATA1;
            end else begin
              fd_nxt            = b;
              res.type_or_data1 = b;
              if (ev[7:4] inside {NIB_PROG, NIB_PRESS}) begin
                res_valid = 1'b1;
                end_evt   = 1'b1;
              end else begin
                phase_nxt = PH_DATA2;
              end
            end
          end else begin
            res_valid = 1'b1;
            end_evt   = 1'b1;
          end
        end
        PH_SKIP: begin
          brem_nxt = brem_dec;
          if (brem_dec == 32'd0) begin
            res_valid = 1'b1;
            end_evt   = 1'b1;
          end
        end
        PH_DATA1: begin
          fd_nxt            = b;
          res.type_or_data1 = b;
          if (c_cs[7:4] inside {NIB_PROG, NIB_PRESS}) begin
            res_valid = 1'b1;
            end_evt   = 1'b1;
          end else begin
            phase_nxt = PH_DATA2;
          end
        end
        PH_DATA2: begin
          sd_nxt    = b;
          res.data2 = b;
          res_valid = 1'b1;
          end_evt   = 1'b1;
        end
        PH_METATYPE: begin
          fd_nxt    = b;
          lacc_nxt  = 32'd0;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          lacc_nxt = {c_lacc[24:0], b[6:0]};
          if (!b[7]) begin
            brem_nxt           = lacc_nxt;
            res_valid          = 1'b1;
            res.payload_length = lacc_nxt;
            res.last           = (lacc_nxt == 32'd0);
            if (lacc_nxt == 32'd0) begin
              end_evt = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          brem_nxt           = brem_dec;
          res_valid          = 1'b1;
          res.kind           = KIND_PAYLOAD;
          res.payload_length = c_lacc;
          res.payload_byte   = b;
          res.last           = (brem_dec == 32'd0);
          end_evt            = (brem_dec == 32'd0);
        end
        default: begin
          phase_nxt = PH_DELTA;
          dacc_nxt  = '0;
        end
      endcase

      if (end_evt) begin
        phase_nxt = PH_DELTA;
        dacc_nxt  = '0;
        if ((cs_nxt == ST_META) && (fd_nxt == META_EOT)) begin
          ended_nxt = 1'b1;
        end
        // Running status with no data bytes: the byte opens the next delta time.
        if ((c_phase == PH_STATUS) && !used && !b[7]) begin
          dacc_nxt  = {{(TW-7){1'b0}}, b[6:0]};
          total_nxt = c_total + dacc_nxt;
          fd_nxt    = 8'd0;
          sd_nxt    = 8'd0;
          lacc_nxt  = 32'd0;
          brem_nxt  = 32'd0;
          phase_nxt = PH_STATUS;
          if (ev[7:4] inside {NIB_PROG, NIB_PRESS} || ev == ST_SONG_SEL) begin
            // Those events consumed the byte as data; undo the reparse.
            dacc_nxt  = '0;
            total_nxt = c_total;
            fd_nxt    = (ev == ST_SONG_SEL) ? c_fd : b;
            sd_nxt    = c_sd;
            lacc_nxt  = c_lacc;
            brem_nxt  = 32'd0;
            phase_nxt = PH_DELTA;
          end
        end
      end
    end

    res.end_of_track = (res.status == ST_META) && (res.type_or_data1 == META_EOT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      rs_r    <= 8'd0;
      cs_r    <= 8'd0;
      dacc_r  <= '0;
      total_r <= '0;
      fd_r    <= 8'd0;
      sd_r    <= 8'd0;
      lacc_r  <= 32'd0;
      brem_r  <= 32'd0;
      ended_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      rs_r    <= rs_nxt;
      cs_r    <= cs_nxt;
      dacc_r  <= dacc_nxt;
      total_r <= total_nxt;
      fd_r    <= fd_nxt;
      sd_r    <= sd_nxt;
      lacc_r  <= lacc_nxt;
      brem_r  <= brem_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

// ----- sv/mtep_out_stage.sv -----
`timescale 1ns / 1ps

module mtep_out_stage
  import mtep_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res,
  output logic load_ok,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign load_ok   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load_ok) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ok) begin
      res_r <= res;
    end
  end

endmodule

// ----- sv/midi_track_event_parser_core.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake             Beat contents
// in_       in   in_valid / in_ready   track_start, data_byte
// out_      out  out_valid / out_ready kind, times, status, data, length, payload, flags
//
// One byte per cycle while the output is not stalled: a byte is registered in the
// input register, where the parser state and the next-state logic work on it,
// and its result, if any, is registered in the output register.
// Reset clears the parser state and both valid flags; no clearing pass.
// A stalled result holds the byte in the input register; input keeps flowing
// while the output register drains.
module midi_track_event_parser_core
  import mtep_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_track_start,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [31:0] out_delta_time,
  output logic [31:0] out_total_time,
  output logic [7:0]  out_status,
  output logic [7:0]  out_type_or_data1,
  output logic [7:0]  out_data2,
  output logic [31:0] out_payload_length,
  output logic [7:0]  out_payload_byte,
  output logic        out_last,
  output logic        out_end_of_track
);

  in_beat_t in_beat;
  in_beat_t held_beat;
  logic     held_valid;
  logic     take;
  logic     load_ok;
  logic     res_valid;
  res_t     res;
  res_t     out_res;

  assign in_beat.track_start = in_track_start;
  assign in_beat.data_byte   = in_data_byte;
  assign take                = held_valid && load_ok;

  mtep_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .take       (take),
    .held_valid (held_valid),
    .held_beat  (held_beat)
  );

  mtep_parse #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (take),
    .beat      (held_beat),
    .res_valid (res_valid),
    .res       (res)
  );

  mtep_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && res_valid),
    .res       (res),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_delta_time     = out_res.delta_time;
  assign out_total_time     = out_res.total_time;
  assign out_status         = out_res.status;
  assign out_type_or_data1  = out_res.type_or_data1;
  assign out_data2          = out_res.data2;
  assign out_payload_length = out_res.payload_length;
  assign out_payload_byte   = out_res.payload_byte;
  assign out_last           = out_res.last;
  assign out_end_of_track   = out_res.end_of_track;

endmodule

// ----- sv/mtep_checker.sv -----
`timescale 1ns / 1ps

module mtep_checker
  import mtep_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [31:0] out_delta_time,
  input logic [31:0] out_total_time,
  input logic [7:0]  out_status,
  input logic [7:0]  out_type_or_data1,
  input logic [7:0]  out_data2,
  input logic [31:0] out_payload_length,
  input logic [7:0]  out_payload_byte,
  input logic        out_last,
  input logic        out_end_of_track
);

  // A stalled result beat must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte)
      && $stable(out_kind) && $stable(out_payload_length) && $stable(out_last)
      && $stable(out_delta_time) && $stable(out_total_time) && $stable(out_status)
      && $stable(out_type_or_data1) && $stable(out_data2) && $stable(out_end_of_track))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_PAYLOAD) |-> out_payload_length != 32'd0)
    else $error("payload beat for an event without payload");

  a_header_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_HEADER) && (out_payload_length != 32'd0) |-> !out_last)
    else $error("header of a payload event marked last");

  a_plain_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !((out_status == ST_META) || (out_status == ST_SYSEX)
      || (out_status == ST_ESCAPE))
      |-> (out_kind == KIND_HEADER) && out_last && (out_payload_length == 32'd0))
    else $error("channel or system event not a single header");

endmodule

bind midi_track_event_parser_core mtep_checker u_mtep_checker (.*);
